// ===== hdl/urc_pkg.sv =====
// Shared types and constants for the ultrasonic ranging controller.
// No dependencies; used by urc_dist and ultrasonic_ranging_controller_unit.
package urc_pkg;

    // Controller phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT
    } t_phase;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_INTERVAL,
        CFG_ECHO_TIMEOUT,
        CFG_MAX_FAULTS,
        CFG_REINIT_COOLDOWN
    } t_cfg_idx;

    localparam int TICKS_PER_MS = 1000;
    localparam logic [9:0]  MS_WRAP      = 10'(TICKS_PER_MS - 1);
    localparam logic [15:0] TRIG_LOW_US  = 16'd2;
    localparam logic [15:0] TRIG_HIGH_US = 16'd10;

    localparam logic [15:0] RST_MIN_INTERVAL    = 16'd200;
    localparam logic [15:0] RST_ECHO_TIMEOUT    = 16'd30000;
    localparam logic [7:0]  RST_MAX_FAULTS      = 8'd10;
    localparam logic [15:0] RST_REINIT_COOLDOWN = 16'd3000;

    // distance = floor(len * 17 / 1000) = (len * DIST_MULT) >> DIST_SHIFT for len < 2^16
    localparam int          DIST_SHIFT = 26;
    localparam logic [20:0] DIST_MULT  = 21'd1140851;

    localparam int DIST_W = 11;

endpackage

// ===== hdl/urc_dist.sv =====
// Echo length to distance conversion: scaled reciprocal multiply.
// Depends on urc_pkg.
module urc_dist (
    input  logic [15:0]                 i_echo_len,
    output logic [urc_pkg::DIST_W-1:0]  o_distance_cm
);

    logic [36:0] w_prod;

    assign w_prod        = {21'd0, i_echo_len} * {16'd0, urc_pkg::DIST_MULT};
    assign o_distance_cm = w_prod[urc_pkg::DIST_SHIFT +: urc_pkg::DIST_W];

endmodule

// ===== hdl/ultrasonic_ranging_controller_unit.sv =====
// Ultrasonic ranging controller, top level. Depends on urc_pkg and urc_dist.
// Latency: a result is presented in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless a held result blocks o_in_ready; the phase logic
// and the distance multiply sit between the state registers and a one-entry output register.
// Reset (synchronous, active low): idle phase, counters cleared, registers
// at their default values, output register empty.
module ultrasonic_ranging_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_echo_level,
    input  logic        i_measure_enable,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_trigger_level,
    output logic        o_result_valid,
    output logic [10:0] o_distance_cm,
    output logic        o_out_of_range,
    output logic [7:0]  o_fault_count,
    output logic        o_reinit_event,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    urc_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [15:0] r_len, n_len;
    logic        r_rise, n_rise;
    logic [9:0]  r_presc, n_presc;
    logic [15:0] r_ms_trig, n_ms_trig;
    logic [15:0] r_ms_reinit, n_ms_reinit;
    logic [7:0]  r_faults, n_faults;

    logic [15:0] r_min_interval, r_echo_timeout, r_cooldown;
    logic [7:0]  r_max_faults;

    logic        r_out_valid;
    logic        r_trig, r_res_valid, r_oor, r_reinit;
    logic [10:0] r_dist;
    logic        n_trig, n_res_valid, n_oor, n_reinit;
    logic [10:0] n_dist;

    logic        w_accept;
    logic        w_start, w_done, w_timeout, w_failed, w_do_reinit, w_ms_tick;
    logic [15:0] w_timer_inc;
    logic [7:0]  w_faults_inc;
    logic [10:0] w_dist;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    urc_dist u_dist (
        .i_echo_len    (r_len),
        .o_distance_cm (w_dist)
    );

    assign w_timer_inc  = r_timer + 16'd1;
    assign w_start      = (r_phase == urc_pkg::PH_IDLE) && i_measure_enable
                          && (r_ms_trig >= r_min_interval);
    assign w_done       = (r_phase == urc_pkg::PH_WAIT) && r_rise && !i_echo_level;
    assign w_timeout    = (r_phase == urc_pkg::PH_WAIT) && !w_done
                          && (r_timer >= r_echo_timeout);
    assign w_failed     = w_timeout || (w_done && (r_len == 16'd0));
    assign w_faults_inc = (r_faults == 8'hFF) ? r_faults : r_faults + 8'd1;
    assign w_do_reinit  = w_failed && (w_faults_inc >= r_max_faults)
                          && (r_ms_reinit > r_cooldown);
    assign w_ms_tick    = (r_presc >= urc_pkg::MS_WRAP);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            urc_pkg::PH_IDLE: begin
                if (w_start) n_phase = urc_pkg::PH_TRIG_LOW;
            end
            urc_pkg::PH_TRIG_LOW: begin
                if (w_timer_inc >= urc_pkg::TRIG_LOW_US) n_phase = urc_pkg::PH_TRIG_HIGH;
            end
            urc_pkg::PH_TRIG_HIGH: begin
                if (w_timer_inc >= urc_pkg::TRIG_HIGH_US) n_phase = urc_pkg::PH_WAIT;
            end
            urc_pkg::PH_WAIT: begin
                if (w_done || w_timeout) n_phase = urc_pkg::PH_IDLE;
            end
            default: n_phase = urc_pkg::PH_IDLE;
        endcase
    end

    // datapath and result fields
    always_comb begin
        n_timer     = r_timer;
        n_len       = r_len;
        n_rise      = r_rise;
        n_ms_trig   = r_ms_trig;
        n_ms_reinit = r_ms_reinit;
        n_faults    = r_faults;
        n_trig      = 1'b0;
        n_res_valid = 1'b0;
        n_dist      = '0;
        n_oor       = w_failed;
        n_reinit    = w_do_reinit;

        unique case (r_phase)
            urc_pkg::PH_IDLE: begin
                if (w_start) begin
                    n_timer   = '0;
                    n_len     = '0;
                    n_rise    = 1'b0;
                    n_ms_trig = '0;
                end
            end
            urc_pkg::PH_TRIG_LOW: begin
                n_timer = (w_timer_inc >= urc_pkg::TRIG_LOW_US) ? 16'd0 : w_timer_inc;
            end
            urc_pkg::PH_TRIG_HIGH: begin
                n_trig = 1'b1;
                if (w_timer_inc >= urc_pkg::TRIG_HIGH_US) begin
                    n_timer = '0;
                    n_len   = '0;
                    n_rise  = 1'b0;
                end else begin
                    n_timer = w_timer_inc;
                end
            end
            urc_pkg::PH_WAIT: begin
                if (w_done) begin
                    n_res_valid = 1'b1;
                    if (r_len != 16'd0) begin
                        n_dist   = w_dist;
                        n_faults = '0;
                    end
                end else if (w_timeout) begin
                    n_res_valid = 1'b1;
                end else begin
                    if (i_echo_level) begin
                        n_rise = 1'b1;
                        n_len  = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
                    end
                    n_timer = (r_timer == 16'hFFFF) ? r_timer : w_timer_inc;
                end
            end
            default: ;
        endcase

        if (w_failed) n_faults = w_faults_inc;
        if (w_do_reinit) begin
            n_faults    = '0;
            n_ms_reinit = '0;
            n_len       = '0;
            n_rise      = 1'b0;
        end

        // millisecond prescaler runs after the phase logic
        if (w_ms_tick) begin
            n_presc     = '0;
            n_ms_trig   = (n_ms_trig == 16'hFFFF) ? n_ms_trig : n_ms_trig + 16'd1;
            n_ms_reinit = (n_ms_reinit == 16'hFFFF) ? n_ms_reinit : n_ms_reinit + 16'd1;
        end else begin
            n_presc = r_presc + 10'd1;
        end
    end

    // controller state: advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= urc_pkg::PH_IDLE;
            r_timer     <= '0;
            r_len       <= '0;
            r_rise      <= 1'b0;
            r_presc     <= '0;
            r_ms_trig   <= '0;
            r_ms_reinit <= '0;
            r_faults    <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_len       <= n_len;
            r_rise      <= n_rise;
            r_presc     <= n_presc;
            r_ms_trig   <= n_ms_trig;
            r_ms_reinit <= n_ms_reinit;
            r_faults    <= n_faults;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= urc_pkg::RST_MIN_INTERVAL;
            r_echo_timeout <= urc_pkg::RST_ECHO_TIMEOUT;
            r_max_faults   <= urc_pkg::RST_MAX_FAULTS;
            r_cooldown     <= urc_pkg::RST_REINIT_COOLDOWN;
        end else if (i_cfg_valid) begin
            unique case (urc_pkg::t_cfg_idx'(i_cfg_index))
                urc_pkg::CFG_MIN_INTERVAL:    r_min_interval <= i_cfg_data;
                urc_pkg::CFG_ECHO_TIMEOUT:    r_echo_timeout <= i_cfg_data;
                urc_pkg::CFG_MAX_FAULTS:      r_max_faults   <= i_cfg_data[7:0];
                urc_pkg::CFG_REINIT_COOLDOWN: r_cooldown     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register: load on transfer in, drop on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trig      <= n_trig;
            r_res_valid <= n_res_valid;
            r_dist      <= n_dist;
            r_oor       <= n_oor;
            r_reinit    <= n_reinit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_trig;
    assign o_result_valid  = r_res_valid;
    assign o_distance_cm   = r_dist;
    assign o_out_of_range  = r_oor;
    assign o_fault_count   = r_faults;
    assign o_reinit_event  = r_reinit;

endmodule
